// File: src/hss_pkg.sv
// Shared constants for the heightmap steepness stencil.
// No dependencies; imported by heightmap_steepness_stencil.
`default_nettype none
package hss_pkg;
    // parameter defaults
    localparam int HSS_MAX_ROW_LENGTH = 4096;
    localparam int HSS_HEIGHT_BITS    = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUALITY_MODE = 2'd2;

    // register field widths
    localparam int ROW_LENGTH_W = 13;
    localparam int ROW_COUNT_W  = 16;
    localparam int MODE_W       = 2;

    // quality modes
    localparam logic [MODE_W-1:0] MODE_FOUR_ROOT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FWD_ROOT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ABS_SUM   = 2'd2;

    // result channel
    localparam int STEEP_W  = 17;
    localparam int OUT_DW   = 24;
endpackage
`default_nettype wire

// File: src/heightmap_steepness_stencil.sv
// Heightmap steepness stencil: line stores, neighbour fetch, shared squarer and
// bit-pair square root under one sequencer. Depends on hss_pkg.
//
// Usage: height samples enter in raster order on the slave stream (i_tdata low
// HEIGHT_BITS bits). Each sample causes zero to three steepness results on the
// master stream: the pixel one row up once a row below exists, and on the
// bottom row also the pixel to the left and, at the row end, the sample itself.
// o_tlast marks the final result of one input transfer, o_tuser the result of
// the final pixel of the image.
// Sequence: an input transfer is followed by the line store reads, then per
// result operand selection, the squarer and accumulator, the root unit
// (skipped in mode 2) and the output register. o_tready is low from an
// accepted transfer until its last result has been taken; a stalled
// receiver holds the sequencer.
// Reset returns the position to row 0, column 0 and the registers to 4096
// pixels, 4096 rows, mode 0; line stores are not cleared. A write to register
// 0, 1 or 2 restarts the image. Configuration is taken on every cycle.
`default_nettype none
module heightmap_steepness_stencil
    import hss_pkg::*;
#(
    parameter int MAX_ROW_LENGTH = HSS_MAX_ROW_LENGTH,
    parameter int HEIGHT_BITS    = HSS_HEIGHT_BITS
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // sample stream; tdata: height_sample
    input  wire                        i_tvalid,
    output logic                       o_tready,
    input  wire [((HEIGHT_BITS+7)/8)*8-1:0] i_tdata,
    // result stream; tdata: steepness; tlast: last_of_run; tuser: last_of_image
    output logic                       o_tvalid,
    input  wire                        i_tready,
    output logic [OUT_DW-1:0]          o_tdata,
    output logic                       o_tlast,
    output logic                       o_tuser,
    // configuration writes
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [CFG_DATA_W-1:0]       i_cfg_data
);
    localparam int AW = $clog2(MAX_ROW_LENGTH);
    localparam int LW = $clog2(MAX_ROW_LENGTH + 1);
    localparam int HB = HEIGHT_BITS;
    localparam int SW = 2 * HEIGHT_BITS + 2;
    localparam int RW = HEIGHT_BITS + 1;
    localparam int MW = HEIGHT_BITS + 3;
    localparam int IW = $clog2(RW);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_SEL  = 6'b000100,
        ST_SQR  = 6'b001000,
        ST_ROOT = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [ROW_LENGTH_W-1:0] r_row_length;
    logic [ROW_COUNT_W-1:0]  r_row_count;
    logic [MODE_W-1:0]       r_mode;
    logic [AW-1:0]           r_col;
    logic [ROW_COUNT_W-1:0]  r_row;

    // line stores
    logic [HB-1:0] mem_older [MAX_ROW_LENGTH];
    logic [HB-1:0] mem_newer [MAX_ROW_LENGTH];
    logic [HB-1:0] r_nq, r_oq;
    logic [AW-1:0] rd_addr_n, rd_addr_o;

    // captured operands
    logic [HB-1:0] r_s, r_vn0, r_vo0, r_vn1, r_vom1, r_vnm1, r_vnm2;
    logic [2:0]    r_pend;
    logic [2:0]    r_cnt;
    logic [HB-1:0] r_d [4];
    logic [2*HB-1:0] r_prod;
    logic [SW-1:0] r_acc;
    logic [MW-1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [IW-1:0] r_it;
    logic [STEEP_W-1:0] r_res;
    logic          r_last_run, r_last_img;

    // effective sizes
    logic [LW-1:0]          len_eff;
    logic [ROW_COUNT_W-1:0] rows_eff;
    logic                   c_last, r_bottom, c_has_right;
    always_comb begin
        if (r_row_length == '0) begin
            len_eff = LW'(1);
        end else if (32'(r_row_length) > 32'(MAX_ROW_LENGTH)) begin
            len_eff = LW'(MAX_ROW_LENGTH);
        end else begin
            len_eff = LW'(r_row_length);
        end
        rows_eff    = (r_row_count == '0) ? ROW_COUNT_W'(1) : r_row_count;
        c_last      = (LW'(r_col) + LW'(1)) == len_eff;
        c_has_right = (LW'(r_col) + LW'(1)) < len_eff;
        r_bottom    = r_row == (rows_eff - ROW_COUNT_W'(1));
    end

    logic in_xfer, out_xfer, read_done, advance;
    assign in_xfer   = i_tvalid && o_tready;
    assign out_xfer  = o_tvalid && i_tready;
    assign read_done = (r_state == ST_READ) && (r_cnt == 3'd4);
    assign advance   = (read_done && r_pend == '0) ||
                       ((r_state == ST_OUT) && out_xfer && r_pend == '0);

    assign o_tready    = r_state == ST_IDLE;
    assign o_tvalid    = r_state == ST_OUT;
    assign o_tdata     = {{(OUT_DW-STEEP_W){1'b0}}, r_res};
    assign o_tlast     = r_last_run;
    assign o_tuser     = r_last_img;
    assign o_cfg_ready = 1'b1;

    // configuration and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= ROW_LENGTH_W'(4096);
            r_row_count  <= ROW_COUNT_W'(4096);
            r_mode       <= MODE_FOUR_ROOT;
            r_col        <= '0;
            r_row        <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROW_LENGTH: begin
                    r_row_length <= i_cfg_data[ROW_LENGTH_W-1:0];
                    r_col <= '0;
                    r_row <= '0;
                end
                REG_ROW_COUNT: begin
                    r_row_count <= i_cfg_data[ROW_COUNT_W-1:0];
                    r_col <= '0;
                    r_row <= '0;
                end
                REG_QUALITY_MODE: begin
                    r_mode <= i_cfg_data[MODE_W-1:0];
                    r_col <= '0;
                    r_row <= '0;
                end
                default: begin
                end
            endcase
        end else if (advance) begin
            if (c_last) begin
                r_col <= '0;
                r_row <= r_bottom ? '0 : r_row + ROW_COUNT_W'(1);
            end else begin
                r_col <= r_col + AW'(1);
            end
        end
    end

    // read addresses by fetch step
    always_comb begin
        unique case (r_cnt)
            3'd0:    rd_addr_n = r_col;
            3'd1:    rd_addr_n = r_col + AW'(1);
            3'd2:    rd_addr_n = r_col - AW'(1);
            default: rd_addr_n = r_col - AW'(2);
        endcase
        rd_addr_o = (r_cnt == 3'd0) ? r_col : r_col - AW'(1);
    end

    // line store ports
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_nq <= mem_newer[rd_addr_n];
            r_oq <= mem_older[rd_addr_o];
        end
        if (read_done) begin
            mem_older[r_col] <= r_vn0;
            mem_newer[r_col] <= r_s;
        end
    end

    // operand selection for the pending result
    logic [HB-1:0] ctr, lft, rgt, upv, dnv;
    logic          sel_last_run, sel_last_img;
    logic [2:0]    sel_clear;
    always_comb begin
        priority if (r_pend[0]) begin
            ctr = r_vn0;
            upv = (r_row >= ROW_COUNT_W'(2)) ? r_vo0 : r_vn0;
            rgt = c_has_right ? r_vn1 : r_vn0;
            lft = (r_col != '0) ? r_vom1 : r_vn0;
            dnv = r_s;
            sel_last_run = !r_pend[1] && !r_pend[2];
            sel_last_img = 1'b0;
            sel_clear    = 3'b001;
        end else if (r_pend[1]) begin
            ctr = r_vnm1;
            lft = (r_col >= AW'(2)) ? r_vnm2 : r_vnm1;
            upv = (r_row != '0) ? r_vom1 : r_vnm1;
            rgt = r_s;
            dnv = r_vnm1;
            sel_last_run = !r_pend[2];
            sel_last_img = 1'b0;
            sel_clear    = 3'b010;
        end else begin
            ctr = r_s;
            lft = (r_col != '0) ? r_vnm1 : r_s;
            upv = (r_row != '0) ? r_vn0 : r_s;
            rgt = r_s;
            dnv = r_s;
            sel_last_run = 1'b1;
            sel_last_img = 1'b1;
            sel_clear    = 3'b100;
        end
    end

    // root step
    logic [MW-1:0] rem_sh, trial;
    logic          fits;
    logic [RW-1:0] root_nx;
    always_comb begin
        rem_sh  = {r_rem[MW-3:0], r_acc[SW-1:SW-2]};
        trial   = {r_root, 2'b01};
        fits    = rem_sh >= trial;
        root_nx = {r_root[RW-2:0], fits};
    end

    logic [2:0] n_terms;
    assign n_terms = (r_mode == MODE_FWD_ROOT) ? 3'd2 : 3'd4;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_xfer) n_state = ST_READ;
            ST_READ: if (read_done) n_state = (r_pend == '0) ? ST_IDLE : ST_SEL;
            ST_SEL:  n_state = ST_SQR;
            ST_SQR: begin
                if (r_mode == MODE_ABS_SUM) n_state = ST_OUT;
                else if (r_cnt == n_terms) n_state = ST_ROOT;
            end
            ST_ROOT: if (r_it == IW'(RW-1)) n_state = ST_OUT;
            ST_OUT:  if (out_xfer) n_state = (r_pend == '0) ? ST_IDLE : ST_SEL;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (in_xfer) begin
                        r_pend <= {r_bottom && c_last, r_bottom && r_col != '0,
                                   r_row != '0};
                    end
                end
                ST_READ: r_cnt <= read_done ? 3'd0 : r_cnt + 3'd1;
                ST_SEL: begin
                    r_cnt  <= '0;
                    r_pend <= r_pend & ~sel_clear;
                end
                ST_SQR:  r_cnt <= r_cnt + 3'd1;
                default: r_cnt <= '0;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) r_s <= i_tdata[HB-1:0];
            end
            ST_READ: begin
                unique case (r_cnt)
                    3'd1: begin
                        r_vn0 <= r_nq;
                        r_vo0 <= r_oq;
                    end
                    3'd2: begin
                        r_vn1  <= r_nq;
                        r_vom1 <= r_oq;
                    end
                    3'd3: r_vnm1 <= r_nq;
                    3'd4: r_vnm2 <= r_nq;
                    default: begin
                    end
                endcase
            end
            ST_SEL: begin
                r_d[0] <= (rgt > ctr) ? rgt - ctr : ctr - rgt;
                r_d[1] <= (dnv > ctr) ? dnv - ctr : ctr - dnv;
                r_d[2] <= (lft > ctr) ? lft - ctr : ctr - lft;
                r_d[3] <= (upv > ctr) ? upv - ctr : ctr - upv;
                r_last_run <= sel_last_run;
                r_last_img <= sel_last_img;
                r_acc <= '0;
            end
            ST_SQR: begin
                if (r_mode == MODE_ABS_SUM) begin
                    r_res <= STEEP_W'({1'b0, r_d[0]} + {1'b0, r_d[1]});
                end else begin
                    if (r_cnt < n_terms) r_prod <= r_d[r_cnt[1:0]] * r_d[r_cnt[1:0]];
                    if (r_cnt != 3'd0) r_acc <= r_acc + SW'(r_prod);
                end
                r_rem  <= '0;
                r_root <= '0;
                r_it   <= '0;
            end
            ST_ROOT: begin
                r_rem  <= fits ? rem_sh - trial : rem_sh;
                r_root <= root_nx;
                r_acc  <= {r_acc[SW-3:0], 2'b00};
                r_it   <= r_it + IW'(1);
                if (r_it == IW'(RW-1)) r_res <= STEEP_W'(root_nx);
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire
